@@ hw/rtl/fsu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the byte-stuffed frame receiver.
// Used by the front, queue, back, checker and top-level files; depends on nothing.
package fsu_pkg;

  // Framing bytes
  localparam logic [7:0] HEAD_BYTE   = 8'hAA;
  localparam logic [7:0] ESCAPE_BYTE = 8'h55;
  localparam logic [7:0] MANGLE_MASK = 8'h20;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  // Queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Frame phase, one-hot; also tags each decoded byte in the queue
  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_LEN_LO  = 6'b000010,
    PH_LEN_HI  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CK_LO   = 6'b010000,
    PH_CK_HI   = 6'b100000
  } rx_phase_t;

  // One decoded byte with the field it belongs to
  typedef struct packed {
    rx_phase_t  phase;
    logic [7:0] data;
  } fsu_entry_t;

endpackage

@@ hw/rtl/fsu_front.sv @@
`timescale 1ns / 1ps
// Front end: head detection, unescaping and field classification.
// Depends on fsu_pkg; pushes tagged bytes into fsu_queue.
module fsu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         in_rx_byte,
  output logic               push,
  output fsu_pkg::fsu_entry_t push_entry
);
  import fsu_pkg::*;

  rx_phase_t   phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [7:0]  dec;
  logic [15:0] len_full;

  assign len_full = {dec, len_lo_r};

  // Decode one raw byte and advance the phase
  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    len_lo_nxt = len_lo_r;
    remain_nxt = remain_r;
    push       = 1'b0;
    dec        = in_rx_byte;
    if (esc_r) begin
      dec = in_rx_byte ^ MANGLE_MASK;
    end
    if (in_fire) begin
      if (phase_r == PH_IDLE) begin
        if (in_rx_byte == HEAD_BYTE) begin
          phase_nxt = PH_LEN_LO;
          esc_nxt   = 1'b0;
        end
      end else if (!esc_r && in_rx_byte == ESCAPE_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        push    = 1'b1;
        unique case (phase_r)
          PH_LEN_LO: begin
            len_lo_nxt = dec;
            phase_nxt  = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            remain_nxt = len_full;
            phase_nxt  = (len_full == 16'd0) ? PH_CK_LO : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            remain_nxt = remain_r - 16'd1;
            if (remain_r == 16'd1) begin
              phase_nxt = PH_CK_LO;
            end
          end
          PH_CK_LO: phase_nxt = PH_CK_HI;
          default:  phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  assign push_entry.phase = phase_r;
  assign push_entry.data  = dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      esc_r    <= 1'b0;
      len_lo_r <= 8'd0;
      remain_r <= 16'd0;
    end else begin
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      len_lo_r <= len_lo_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

@@ hw/rtl/fsu_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO of tagged bytes between the front and the back end.
// Depends on fsu_pkg for the entry type and depth.
module fsu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fsu_pkg::fsu_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output fsu_pkg::fsu_entry_t head_entry
);
  import fsu_pkg::*;

  fsu_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty  = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ hw/rtl/fsu_back.sv @@
`timescale 1ns / 1ps
// Back end: checksum accumulation, length capture and result register.
// Depends on fsu_pkg; consumes tagged bytes from fsu_queue.
module fsu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  fsu_pkg::fsu_entry_t q_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_byte,
  output logic [15:0]         out_frame_length,
  output logic                out_is_last
);
  import fsu_pkg::*;

  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic        last_r, last_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] len_seen_r, len_seen_nxt;
  logic [7:0]  ck_lo_r, ck_lo_nxt;
  logic [15:0] sum_add;
  logic [15:0] ck_total;

  // Take a byte when the result register is free or being emptied
  assign pop      = q_not_empty && (!valid_r || out_ready);
  assign sum_add  = sum_r + {8'd0, q_entry.data};
  assign ck_total = {q_entry.data, ck_lo_r} + sum_r;

  always_comb begin
    valid_nxt    = valid_r && !out_ready;
    kind_nxt     = kind_r;
    byte_nxt     = byte_r;
    flen_nxt     = flen_r;
    last_nxt     = last_r;
    sum_nxt      = sum_r;
    len_lo_nxt   = len_lo_r;
    len_seen_nxt = len_seen_r;
    ck_lo_nxt    = ck_lo_r;
    if (pop) begin
      unique case (q_entry.phase)
        PH_LEN_LO: begin
          // first byte of a frame restarts the sum
          sum_nxt    = {8'd0, q_entry.data};
          len_lo_nxt = q_entry.data;
        end
        PH_LEN_HI: begin
          sum_nxt      = sum_add;
          len_seen_nxt = {q_entry.data, len_lo_r};
        end
        PH_PAYLOAD: begin
          sum_nxt   = sum_add;
          valid_nxt = 1'b1;
          kind_nxt  = KIND_PAYLOAD;
          byte_nxt  = q_entry.data;
          flen_nxt  = 16'd0;
          last_nxt  = 1'b0;
        end
        PH_CK_LO: ck_lo_nxt = q_entry.data;
        PH_CK_HI: begin
          // received + sum wraps to zero when the checksum matches
          valid_nxt = 1'b1;
          kind_nxt  = (ck_total == 16'd0) ? KIND_GOOD : KIND_BAD;
          byte_nxt  = 8'd0;
          flen_nxt  = len_seen_r;
          last_nxt  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sum_r      <= 16'd0;
      len_lo_r   <= 8'd0;
      len_seen_r <= 16'd0;
      ck_lo_r    <= 8'd0;
    end else begin
      valid_r    <= valid_nxt;
      sum_r      <= sum_nxt;
      len_lo_r   <= len_lo_nxt;
      len_seen_r <= len_seen_nxt;
      ck_lo_r    <= ck_lo_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    flen_r <= flen_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_byte         = byte_r;
  assign out_frame_length = flen_r;
  assign out_is_last      = last_r;

endmodule

@@ hw/rtl/frame_unstuff_checksum_rx_core.sv @@
`timescale 1ns / 1ps
// Top level of the byte-stuffed frame receiver with 16-bit sum checksum.
// Depends on fsu_pkg, fsu_front, fsu_queue and fsu_back.
//
// The receiver takes one raw byte per cycle while in_ready is high: the
// front end unescapes and classifies each byte in the cycle it is accepted,
// and the back end updates the checksum and fills a one-entry result
// register, one byte per cycle while that register is free or being emptied.
// A four-entry queue between them lets either side stall alone; in_ready
// drops only while that queue holds four bytes. A payload byte or frame-end
// result passes through the queue and the result register; bytes outside a
// frame are dropped until head byte 0xAA; an 0xAA inside one is ordinary data.
module frame_unstuff_checksum_rx_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_frame_length,
  output logic        out_is_last
);
  import fsu_pkg::*;

  logic       in_fire;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;
  fsu_entry_t push_entry;
  fsu_entry_t head_entry;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  fsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  fsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head_entry (head_entry)
  );

  fsu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_entry          (head_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_frame_length (out_frame_length),
    .out_is_last      (out_is_last)
  );

endmodule

@@ hw/rtl/fsu_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the frame receiver, bound to the top level.
// Depends on fsu_pkg for the result kind codes.
module fsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic [15:0] out_frame_length,
  input logic        out_is_last
);
  import fsu_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Frame end carries a checksum verdict and a zero byte
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |->
      (out_kind == KIND_GOOD || out_kind == KIND_BAD) && out_byte == 8'd0)
    else $error("frame end with wrong kind or byte");

  // Payload results carry no length
  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |->
      out_kind == KIND_PAYLOAD && out_frame_length == 16'd0)
    else $error("payload result with wrong kind or length");

endmodule

bind frame_unstuff_checksum_rx_core fsu_checker u_fsu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_byte         (out_byte),
  .out_frame_length (out_frame_length),
  .out_is_last      (out_is_last)
);
